>>> hdl/ipdr_pkg.sv
// Shared constants, types and helpers for the int8 packed dot product with requantize.
// Used by every module of the block; has no dependencies of its own.
package ipdr_pkg;

   // Lane arrangement: elements are handled in groups of one byte lane per element
   localparam int LANES      = 32;
   localparam int GROUP_SIZE = 8;
   localparam int GROUPS     = (LANES + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int WORDS      = 4;
   localparam int WORD_W     = 64;
   localparam int ELEM_W     = 8;

   // Datapath widths
   localparam int PROD_W = 2 * ELEM_W;           // one signed 8x8 product
   localparam int GSUM_W = PROD_W + 3;           // sum of eight products
   localparam int TOT_W  = GSUM_W + 2;           // sum of up to four groups
   localparam int ACC_W  = 32;                   // wrapping row accumulator
   localparam int RES_W  = 8;

   // Configuration widths and limits
   localparam int PPR_W     = 13;
   localparam int ROWS_W    = 16;
   localparam int PIDX_W    = 12;
   localparam int MAX_PACKS = 4096;

   // Division by 127: floor(a / 127) = (a * RECIP_127) >> RECIP_SHIFT for a <= 2^31
   localparam logic [ACC_W-1:0] RECIP_127   = 32'd2164392969;
   localparam int               RECIP_SHIFT = 38;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      REG_PACKS_PER_ROW = 1'b0,
      REG_ROW_COUNT     = 1'b1
   } csr_reg_type;

   typedef logic signed [GSUM_W-1:0] gsum_type;

   // Finished row sum handed from the merge stage to the requantizer
   typedef struct packed {
      logic             valid;
      logic [ACC_W-1:0] sum;
      logic             last;
   } row_type;

   // Requantized result handed to the output buffer
   typedef struct packed {
      logic             valid;
      logic [RES_W-1:0] result;
      logic             last;
   } res_type;

   // Byte mask that zeroes elements at or beyond LANES inside one group
   function automatic logic [WORD_W-1:0] byte_mask(input int group);
      logic [WORD_W-1:0] mask;
      mask = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
         if (group * GROUP_SIZE + j < LANES) begin
            mask[j*ELEM_W +: ELEM_W] = {ELEM_W{1'b1}};
         end
      end
      return mask;
   endfunction

endpackage

>>> hdl/ipdr_lane.sv
// One lane group: eight signed byte multipliers and the adder that sums their products.
// Depends on ipdr_pkg for widths and the group sum type.
module ipdr_lane (
   input  logic                          clock,
   input  logic                          ce,
   input  logic [ipdr_pkg::WORD_W-1:0]   matrix_word,
   input  logic [ipdr_pkg::WORD_W-1:0]   vector_word,
   output ipdr_pkg::gsum_type            group_sum
);

   logic signed [ipdr_pkg::PROD_W-1:0] prod_in [ipdr_pkg::GROUP_SIZE];
   logic signed [ipdr_pkg::PROD_W-1:0] prod_ff [ipdr_pkg::GROUP_SIZE];
   ipdr_pkg::gsum_type                 sum_in;
   ipdr_pkg::gsum_type                 sum_ff;

   // Multiply each byte pair
   always_comb begin
      for (int j = 0; j < ipdr_pkg::GROUP_SIZE; j++) begin
         prod_in[j] = $signed(matrix_word[j*ipdr_pkg::ELEM_W +: ipdr_pkg::ELEM_W])
                    * $signed(vector_word[j*ipdr_pkg::ELEM_W +: ipdr_pkg::ELEM_W]);
      end
   end

   // Sum the registered products of the group
   always_comb begin
      sum_in = '0;
      for (int j = 0; j < ipdr_pkg::GROUP_SIZE; j++) begin
         sum_in = sum_in + ipdr_pkg::GSUM_W'(prod_ff[j]);
      end
   end

   // Advance both stages together
   always_ff @(posedge clock) begin
      if (ce) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   assign group_sum = sum_ff;

endmodule

>>> hdl/ipdr_merge.sv
// Merge stage: adds the lane group sums, accumulates packs into the row sum
// and tracks pack and row position. Depends on ipdr_pkg.
module ipdr_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ce,
   input  logic                          in_valid,
   input  ipdr_pkg::gsum_type            group_sum [ipdr_pkg::GROUPS],
   input  logic [ipdr_pkg::PPR_W-1:0]    packs_per_row,
   input  logic [ipdr_pkg::ROWS_W-1:0]   row_count,
   output ipdr_pkg::row_type             row_out
);

   logic signed [ipdr_pkg::TOT_W-1:0]  total_in;
   logic signed [ipdr_pkg::TOT_W-1:0]  total_ff;
   logic                               total_valid_ff;
   logic [ipdr_pkg::ACC_W-1:0]         row_sum_ff;
   logic [ipdr_pkg::PIDX_W-1:0]        pack_index_ff;
   logic [ipdr_pkg::ROWS_W-1:0]        row_index_ff;
   logic                               out_valid_ff;
   logic [ipdr_pkg::ACC_W-1:0]         out_sum_ff;
   logic                               out_last_ff;

   logic [ipdr_pkg::ACC_W-1:0]         sum_now;
   logic [ipdr_pkg::PPR_W-1:0]         eff_packs;
   logic [ipdr_pkg::PPR_W-1:0]         pack_next;
   logic [ipdr_pkg::ROWS_W-1:0]        eff_rows;
   logic [ipdr_pkg::ROWS_W:0]          row_next;
   logic                               row_end;
   logic                               row_last;

   // Combine the lane groups
   always_comb begin
      total_in = '0;
      for (int g = 0; g < ipdr_pkg::GROUPS; g++) begin
         total_in = total_in + ipdr_pkg::TOT_W'(group_sum[g]);
      end
   end

   // Clamp counts and decide row end and last row
   always_comb begin
      if (packs_per_row == '0) begin
         eff_packs = ipdr_pkg::PPR_W'(1);
      end else if (packs_per_row > ipdr_pkg::PPR_W'(ipdr_pkg::MAX_PACKS)) begin
         eff_packs = ipdr_pkg::PPR_W'(ipdr_pkg::MAX_PACKS);
      end else begin
         eff_packs = packs_per_row;
      end
      eff_rows  = (row_count == '0) ? ipdr_pkg::ROWS_W'(1) : row_count;
      pack_next = {1'b0, pack_index_ff} + ipdr_pkg::PPR_W'(1);
      row_next  = {1'b0, row_index_ff} + (ipdr_pkg::ROWS_W + 1)'(1);
      row_end   = pack_next >= eff_packs;
      row_last  = row_next >= {1'b0, eff_rows};
      sum_now   = row_sum_ff + ipdr_pkg::ACC_W'(total_ff);
   end

   // Register the group total
   always_ff @(posedge clock) begin
      if (reset) begin
         total_valid_ff <= 1'b0;
      end else if (ce) begin
         total_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         total_ff <= total_in;
      end
   end

   // Accumulate the pack, close the row at its last pack
   always_ff @(posedge clock) begin
      if (reset) begin
         row_sum_ff    <= '0;
         pack_index_ff <= '0;
         row_index_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else if (ce) begin
         out_valid_ff <= total_valid_ff & row_end;
         if (total_valid_ff) begin
            if (row_end) begin
               row_sum_ff    <= '0;
               pack_index_ff <= '0;
               row_index_ff  <= row_last ? '0 : row_next[ipdr_pkg::ROWS_W-1:0];
            end else begin
               row_sum_ff    <= sum_now;
               pack_index_ff <= pack_next[ipdr_pkg::PIDX_W-1:0];
            end
         end
      end
   end

   // Hold the finished row sum for the requantizer
   always_ff @(posedge clock) begin
      if (ce && total_valid_ff && row_end) begin
         out_sum_ff  <= sum_now;
         out_last_ff <= row_last;
      end
   end

   assign row_out.valid = out_valid_ff;
   assign row_out.sum   = out_sum_ff;
   assign row_out.last  = out_last_ff;

endmodule

>>> hdl/ipdr_requant.sv
// Requantizer: signed row sum divided by 127 toward zero, low 8 bits kept.
// Magnitude stage, reciprocal multiply stage, then sign restore. Depends on ipdr_pkg.
module ipdr_requant (
   input  logic                clock,
   input  logic                reset,
   input  logic                ce,
   input  ipdr_pkg::row_type   row_in,
   output ipdr_pkg::res_type   res_out
);

   logic                                  mag_valid_ff;
   logic [ipdr_pkg::ACC_W-1:0]            mag_in;
   logic [ipdr_pkg::ACC_W-1:0]            mag_ff;
   logic                                  mag_neg_ff;
   logic                                  mag_last_ff;

   logic [2*ipdr_pkg::ACC_W-1:0]          prod;
   logic                                  quo_valid_ff;
   logic [ipdr_pkg::RES_W-1:0]            quo_ff;
   logic                                  quo_neg_ff;
   logic                                  quo_last_ff;

   // Take the magnitude of the signed sum
   assign mag_in = row_in.sum[ipdr_pkg::ACC_W-1] ? (~row_in.sum + ipdr_pkg::ACC_W'(1))
                                                 : row_in.sum;

   // Multiply by the reciprocal and keep the low quotient bits
   assign prod = (2*ipdr_pkg::ACC_W)'(mag_ff) * (2*ipdr_pkg::ACC_W)'(ipdr_pkg::RECIP_127);

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
         quo_valid_ff <= 1'b0;
      end else if (ce) begin
         mag_valid_ff <= row_in.valid;
         quo_valid_ff <= mag_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         mag_ff      <= mag_in;
         mag_neg_ff  <= row_in.sum[ipdr_pkg::ACC_W-1];
         mag_last_ff <= row_in.last;
         quo_ff      <= prod[ipdr_pkg::RECIP_SHIFT +: ipdr_pkg::RES_W];
         quo_neg_ff  <= mag_neg_ff;
         quo_last_ff <= mag_last_ff;
      end
   end

   // Restore the sign; wraps in 8 bits
   assign res_out.valid  = quo_valid_ff;
   assign res_out.result = quo_neg_ff ? (~quo_ff + ipdr_pkg::RES_W'(1)) : quo_ff;
   assign res_out.last   = quo_last_ff;

endmodule

>>> hdl/int8_packed_dot_requant_top.sv
// Top level of the int8 packed dot product with requantize: register port,
// lane groups, merge, requantizer and output skid buffer. Depends on ipdr_pkg and all ipdr_ modules.
//
// Channel   Direction  Handshake                 Payload
// req_      in         req_tvalid / req_tready   req_tdata: matrix_word_0..3, vector_word_0..3
// rsp_      out        rsp_tvalid / rsp_tready   rsp_tdata: row_result; rsp_tlast: last_row
// csr_      in         psel / penable / pready   packs_per_row at 0x0, row_count at 0x4
//
// One item is taken every cycle while req_tready is high. A row's result reaches the output
// register from the edge that accepts its last pack through two lane stages, the first
// loading at that edge, two merge stages and two requantizer stages. Reset is synchronous
// and clears all valid bits, the row position and the accumulator; the block accepts
// items in the first cycle after it.
// When the output is stalled one extra result is parked in a skid register, and req_tready
// falls only while that register is occupied.
module int8_packed_dot_requant_top (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [63:0] matrix_word_0, [127:64] matrix_word_1, [191:128] matrix_word_2,
   // [255:192] matrix_word_3, [319:256] vector_word_0, [383:320] vector_word_1,
   // [447:384] vector_word_2, [511:448] vector_word_3
   input  logic [2*ipdr_pkg::WORDS*ipdr_pkg::WORD_W-1:0] req_tdata,

   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] row_result
   output logic [ipdr_pkg::RES_W-1:0]        rsp_tdata,
   output logic                              rsp_tlast,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ipdr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ipdr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ipdr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   logic [ipdr_pkg::PPR_W-1:0]   packs_per_row_ff;
   logic [ipdr_pkg::ROWS_W-1:0]  row_count_ff;
   ipdr_pkg::csr_reg_type        csr_reg;
   logic                         csr_write;

   logic                         ce;
   logic                         prod_valid_ff;
   logic                         gsum_valid_ff;
   logic [ipdr_pkg::WORD_W-1:0]  mat_word [ipdr_pkg::WORDS];
   logic [ipdr_pkg::WORD_W-1:0]  vec_word [ipdr_pkg::WORDS];
   ipdr_pkg::gsum_type           group_sum [ipdr_pkg::GROUPS];
   ipdr_pkg::row_type            row_done;
   ipdr_pkg::res_type            res;
   logic                         res_take;

   logic                         out_valid_ff;
   logic [ipdr_pkg::RES_W-1:0]   out_result_ff;
   logic                         out_last_ff;
   logic                         skid_valid_ff;
   logic [ipdr_pkg::RES_W-1:0]   skid_result_ff;
   logic                         skid_last_ff;
   logic                         out_pop;

   // Register port: write on the access cycle, read the selected register
   assign csr_reg    = ipdr_pkg::csr_reg_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         packs_per_row_ff <= ipdr_pkg::PPR_W'(1);
         row_count_ff     <= ipdr_pkg::ROWS_W'(1);
      end else if (csr_write) begin
         case (csr_reg)
            ipdr_pkg::REG_PACKS_PER_ROW: packs_per_row_ff <= csr_pwdata[ipdr_pkg::PPR_W-1:0];
            ipdr_pkg::REG_ROW_COUNT:     row_count_ff     <= csr_pwdata[ipdr_pkg::ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         ipdr_pkg::REG_PACKS_PER_ROW: csr_prdata = ipdr_pkg::CSR_DATA_W'(packs_per_row_ff);
         ipdr_pkg::REG_ROW_COUNT:     csr_prdata = ipdr_pkg::CSR_DATA_W'(row_count_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // Pipeline advances whenever the skid register is free
   assign ce         = ~skid_valid_ff;
   assign req_tready = ce;

   // Split the item into its words
   always_comb begin
      for (int w = 0; w < ipdr_pkg::WORDS; w++) begin
         mat_word[w] = req_tdata[w*ipdr_pkg::WORD_W +: ipdr_pkg::WORD_W];
         vec_word[w] = req_tdata[(ipdr_pkg::WORDS + w)*ipdr_pkg::WORD_W +: ipdr_pkg::WORD_W];
      end
   end

   // Valid bits following the two lane stages
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         gsum_valid_ff <= 1'b0;
      end else if (ce) begin
         prod_valid_ff <= req_tvalid;
         gsum_valid_ff <= prod_valid_ff;
      end
   end

   // Lane groups side by side
   for (genvar g = 0; g < ipdr_pkg::GROUPS; g++) begin : gen_lane
      ipdr_lane u_lane (
         .clock       (clock),
         .ce          (ce),
         .matrix_word (mat_word[g] & ipdr_pkg::byte_mask(g)),
         .vector_word (vec_word[g] & ipdr_pkg::byte_mask(g)),
         .group_sum   (group_sum[g])
      );
   end

   ipdr_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .ce            (ce),
      .in_valid      (gsum_valid_ff),
      .group_sum     (group_sum),
      .packs_per_row (packs_per_row_ff),
      .row_count     (row_count_ff),
      .row_out       (row_done)
   );

   ipdr_requant u_requant (
      .clock   (clock),
      .reset   (reset),
      .ce      (ce),
      .row_in  (row_done),
      .res_out (res)
   );

   // Output register with one skid entry behind it
   assign out_pop  = out_valid_ff & rsp_tready;
   assign res_take = res.valid & ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (~out_valid_ff | out_pop) begin
         out_valid_ff  <= skid_valid_ff | res_take;
         skid_valid_ff <= 1'b0;
      end else if (res_take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (~out_valid_ff | out_pop) begin
         out_result_ff <= skid_valid_ff ? skid_result_ff : res.result;
         out_last_ff   <= skid_valid_ff ? skid_last_ff : res.last;
      end else if (res_take) begin
         skid_result_ff <= res.result;
         skid_last_ff   <= res.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_result_ff;
   assign rsp_tlast  = out_last_ff;

   // A parked result always has a result in front of it
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry occupied while output register is empty");

   // A result arriving at a stalled, full output register is parked, not dropped
   a_park_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready && res_take) |=> skid_valid_ff)
      else $error("result lost while output stalled");

   // The skid entry only fills under an output stall
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready))
      else $error("skid entry filled without an output stall");

endmodule

>>> tb/sv/ipdr_tb_pkg.sv
`timescale 1ns / 1ps
// Row predictor and result checker for the int8 packed dot product testbench.
// Depends on ipdr_pkg for widths, limits and register codes.
package ipdr_tb_pkg;
   import ipdr_pkg::*;

   localparam int PACK_W       = 2 * WORDS * WORD_W;
   localparam int MATRIX_W     = WORDS * WORD_W;
   localparam int REQUANT_DIV  = 127;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [RES_W-1:0] result;
      logic             last;
   } row_out_type;

   // Tracks row position and accumulator, holds the rows still owed by the block
   class dot_row_checker;
      logic [PPR_W-1:0]  packs_reg;
      logic [ROWS_W-1:0] rows_reg;
      logic [ACC_W-1:0]  row_acc;
      logic [PIDX_W-1:0] pack_pos;
      logic [ROWS_W-1:0] row_pos;
      row_out_type       expected_rows[$];
      int                failures;

      function new();
         packs_reg = PPR_W'(1);
         rows_reg  = ROWS_W'(1);
         row_acc   = '0;
         pack_pos  = '0;
         row_pos   = '0;
         failures  = 0;
      endfunction

      function void write_reg(csr_reg_type sel, logic [CSR_DATA_W-1:0] value);
         if (sel == REG_PACKS_PER_ROW) begin
            packs_reg = value[PPR_W-1:0];
         end else begin
            rows_reg = value[ROWS_W-1:0];
         end
      endfunction

      function int outstanding();
         return expected_rows.size();
      endfunction

      // Accumulate one item; close the row when its pack count is reached
      function void take_pack(logic [PACK_W-1:0] pack);
         byte  a;
         byte  b;
         int   prod;
         int   packs_eff;
         int   rows_eff;
         int   quotient;
         logic last;
         for (int k = 0; k < LANES; k++) begin
            a = pack[ELEM_W*k +: ELEM_W];
            b = pack[MATRIX_W + ELEM_W*k +: ELEM_W];
            prod = a * b;
            row_acc = row_acc + prod;
         end
         // zero acts as one, anything above the maximum is clamped
         packs_eff = (packs_reg == 0) ? 1 : (packs_reg > MAX_PACKS) ? MAX_PACKS : packs_reg;
         rows_eff  = (rows_reg == 0) ? 1 : rows_reg;
         if (int'(pack_pos) + 1 < packs_eff) begin
            pack_pos = pack_pos + 1'b1;
            return;
         end
         // signed division truncates toward zero; keep the low byte
         quotient = $signed(row_acc) / REQUANT_DIV;
         last = (int'(row_pos) + 1 >= rows_eff);
         expected_rows.push_back('{result: RES_W'(quotient), last: last});
         row_acc  = '0;
         pack_pos = '0;
         row_pos  = last ? '0 : row_pos + 1'b1;
      endfunction

      function void report(string what);
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("%0t: %s", $time, what);
         end
      endfunction

      // Compare one delivered row against the oldest one owed
      function void check_row(logic [RES_W-1:0] result, logic last);
         row_out_type want;
         if (expected_rows.size() == 0) begin
            report($sformatf("unexpected row result %0d last %0b", $signed(result), last));
            return;
         end
         want = expected_rows.pop_front();
         if (want.result != result || want.last != last) begin
            report($sformatf("row result expected %0d last %0b, got %0d last %0b",
                             $signed(want.result), want.last, $signed(result), last));
         end
      endfunction
   endclass

endpackage

>>> tb/sv/int8_packed_dot_requant_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for int8_packed_dot_requant_top: drives packs and register writes,
// checks every row result through dot_row_checker. Depends on ipdr_pkg and ipdr_tb_pkg.
module int8_packed_dot_requant_top_tb;
   import ipdr_pkg::*;
   import ipdr_tb_pkg::*;

   localparam int RANDOM_ITEMS  = 420;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 2000;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HELD} rx_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PACK_W-1:0]     req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RES_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dot_row_checker sb;
   int             burst_left;
   int             quiet_cycles;

   int8_packed_dot_requant_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Every lane carries the same matrix byte and the same vector byte
   function automatic logic [PACK_W-1:0] fill_pack(input byte m, input byte v);
      logic [PACK_W-1:0] pack;
      for (int k = 0; k < LANES; k++) begin
         pack[ELEM_W*k +: ELEM_W] = m;
         pack[MATRIX_W + ELEM_W*k +: ELEM_W] = v;
      end
      return pack;
   endfunction

   // One active lane, all others zero
   function automatic logic [PACK_W-1:0] one_lane(input int lane, input byte m, input byte v);
      logic [PACK_W-1:0] pack;
      pack = '0;
      pack[ELEM_W*lane +: ELEM_W] = m;
      pack[MATRIX_W + ELEM_W*lane +: ELEM_W] = v;
      return pack;
   endfunction

   function automatic logic [PACK_W-1:0] random_pack();
      logic [PACK_W-1:0] pack;
      for (int w = 0; w < PACK_W / 32; w++) begin
         pack[32*w +: 32] = $urandom;
      end
      // push some bytes to the ends of the byte range or to plus or minus one
      if ($urandom_range(0, 3) == 0) begin
         for (int k = 0; k < 2 * LANES; k++) begin
            case ($urandom_range(0, 5))
               0: pack[ELEM_W*k +: ELEM_W] = 8'h80;
               1: pack[ELEM_W*k +: ELEM_W] = 8'h7F;
               2: pack[ELEM_W*k +: ELEM_W] = 8'hFF;
               3: pack[ELEM_W*k +: ELEM_W] = 8'h01;
               default: ;
            endcase
         end
      end
      return pack;
   endfunction

   // Send one item, opening a new burst after a random gap when the last one ran out
   task automatic send_pack(input logic [PACK_W-1:0] pack);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = pack;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   // Hold the sender until every owed row has come back, then let the pipeline settle
   task automatic wait_results_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_type sel, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {sel, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(sel, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] packs,
                               input logic [CSR_DATA_W-1:0] rows);
      wait_results_idle();
      write_csr(REG_PACKS_PER_ROW, packs);
      write_csr(REG_ROW_COUNT, rows);
   endtask

   // Receiver: stall pattern is redrawn for each segment of random length
   initial begin
      int          seg_left;
      rx_mode_type mode;
      rsp_tready = 1'b0;
      seg_left   = 0;
      mode       = RX_OPEN;
      forever begin
         @(negedge clock);
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 80);
            mode = rx_mode_type'($urandom_range(0, 3));
         end
         seg_left--;
         case (mode)
            RX_OPEN:   rsp_tready = 1'b1;
            RX_COIN:   rsp_tready = 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready = (seg_left % 4 == 0);
            default:   rsp_tready = (seg_left < 6);
         endcase
      end
   end

   // Sample both channels and guard against a hung block
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.take_pack(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_row(rsp_tdata, rsp_tlast);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL int8_packed_dot_requant_top");
            $finish;
         end
      end
   end

   initial begin
      int                    sent;
      int                    count;
      logic [CSR_DATA_W-1:0] packs;
      logic [CSR_DATA_W-1:0] rows;
      sb           = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      burst_left   = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // Reset geometry: every item closes a row. Byte extremes and rounding toward zero.
      send_pack(fill_pack(8'h00, 8'h00));
      send_pack(fill_pack(8'hFF, 8'hFF));
      send_pack(fill_pack(8'h7F, 8'h7F));
      send_pack(fill_pack(8'h80, 8'h80));
      send_pack(fill_pack(8'h80, 8'h7F));
      send_pack(one_lane(0, 8'h81, 8'h01));
      send_pack(one_lane(5, 8'h82, 8'h01));
      send_pack(one_lane(31, 8'h7F, 8'h01));
      send_pack(fill_pack(8'h55, 8'hAA));
      send_pack(fill_pack(8'hAA, 8'h55));

      // Zero counts behave as one
      set_geometry(0, 0);
      repeat (2) send_pack(random_pack());

      // Shrink the row count down to the current row index
      set_geometry(2, 5);
      repeat (4) send_pack(random_pack());
      wait_results_idle();
      write_csr(REG_ROW_COUNT, 2);
      repeat (2) send_pack(random_pack());

      // Oversize pack count mid-row, then cut the row short
      wait_results_idle();
      write_csr(REG_PACKS_PER_ROW, 8191);
      repeat (3) send_pack(random_pack());
      wait_results_idle();
      write_csr(REG_PACKS_PER_ROW, 1);
      send_pack(random_pack());

      // Random phases; a phase may end mid-row so the next write lands inside a row
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       packs = 0;
            5:       packs = $urandom_range(5, 12);
            6:       packs = 16;
            default: packs = $urandom_range(1, 4);
         endcase
         case ($urandom_range(0, 7))
            0:       rows = 0;
            1:       rows = 65535;
            2:       rows = 1;
            3:       rows = $urandom_range(2, 9);
            default: rows = $urandom_range(1, 4);
         endcase
         // unused upper bits of the write data must not matter
         if ($urandom_range(0, 3) == 0) begin
            packs = packs | ($urandom << PPR_W);
            rows  = rows | ($urandom << ROWS_W);
         end
         set_geometry(packs, rows);
         count = $urandom_range(8, 60);
         repeat (count) begin
            if ($urandom_range(0, 19) == 0) begin
               send_pack(fill_pack(8'h80, 8'h80));
            end else begin
               send_pack(random_pack());
            end
            // pause now and then until the block has delivered everything
            if ($urandom_range(0, 49) == 0) begin
               wait_results_idle();
            end
         end
         sent += count;
      end

      wait_results_idle();
      if (sb.failures == 0) begin
         $display("PASS int8_packed_dot_requant_top");
      end else begin
         $display("FAIL int8_packed_dot_requant_top");
      end
      $finish;
   end

endmodule
